// ----- sv/emsi_pkg.sv -----
package emsi_pkg;

  localparam int unsigned MAX_BODY_DEF = 4096;
  localparam logic [12:0] LIMIT_RESET  = 13'd4096;

  localparam int unsigned WIN_BYTES = 14;
  localparam int unsigned WIN_W     = 8 * WIN_BYTES;
  localparam int unsigned DAT_W     = 80;
  localparam int unsigned TAG_LEN   = 6;

  localparam logic [55:0]      SEQ_LEAD  = "**EMSI_";
  localparam logic [WIN_W-1:0] SEQ_REQ   = {SEQ_LEAD, "REQA77E"};
  localparam logic [WIN_W-1:0] SEQ_ACK   = {SEQ_LEAD, "ACKA490"};
  localparam logic [WIN_W-1:0] SEQ_NAK   = {SEQ_LEAD, "NAKEEC3"};
  localparam logic [DAT_W-1:0] SEQ_DAT   = {SEQ_LEAD, "DAT"};
  localparam logic [63:0]      CRC_SEED_STR = SEQ_DAT[63:0];

  localparam logic [15:0] CRC_POLY = 16'h1021;

  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_REQ     = 3'd1,
    EV_ACK     = 3'd2,
    EV_NAK     = 3'd3,
    EV_GOOD    = 3'd4,
    EV_BAD_LEN = 3'd5,
    EV_BAD_CRC = 3'd6,
    EV_BAD_TAG = 3'd7
  } event_t;

  typedef enum logic [3:0] {
    PH_SEARCH = 4'b0001,
    PH_LENGTH = 4'b0010,
    PH_BODY   = 4'b0100,
    PH_CRC    = 4'b1000
  } phase_t;

  typedef struct packed {
    event_t      event_res;
    logic        data_valid;
    logic [7:0]  data_byte;
    logic [11:0] data_index;
  } result_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

  function automatic logic [15:0] crc_seed();
    logic [15:0] c;
    c = 16'h0000;
    for (int k = 7; k >= 0; k--) begin
      c = crc_byte(c, CRC_SEED_STR[8*k +: 8]);
    end
    return c;
  endfunction

  localparam logic [15:0] CRC_INIT = crc_seed();

  // bit 4 set marks a non-hex character
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] v;
    if (c >= "0" && c <= "9") begin
      v = 5'(c - "0");
    end else if (c >= "A" && c <= "F") begin
      v = 5'(c - "A" + 8'd10);
    end else if (c >= "a" && c <= "f") begin
      v = 5'(c - "a" + 8'd10);
    end else begin
      v = 5'd16;
    end
    return v;
  endfunction

  function automatic logic [7:0] tag_byte(input logic [2:0] idx);
    logic [7:0] t;
    case (idx)
      3'd0:    t = "{";
      3'd1:    t = "E";
      3'd2:    t = "M";
      3'd3:    t = "S";
      3'd4:    t = "I";
      3'd5:    t = "}";
      default: t = 8'h00;
    endcase
    return t;
  endfunction

endpackage

// ----- sv/emsi_core.sv -----
module emsi_core #(
  parameter int unsigned MAX_BODY = emsi_pkg::MAX_BODY_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic [7:0]          rx_byte,
  input  logic [12:0]         length_limit,
  output emsi_pkg::result_t   res
);

  localparam logic [15:0] MaxBodyW = 16'(MAX_BODY);

  emsi_pkg::phase_t                   phase_r, phase_nxt;
  logic [emsi_pkg::WIN_W-1:0]         win_r, win_nxt, win_new;
  logic [15:0]                        body_len_r, body_len_nxt, len_new;
  logic [12:0]                        taken_r, taken_nxt;
  logic [15:0]                        crc_r, crc_nxt;
  logic [15:0]                        rx_crc_r, rx_crc_nxt, rx_new;
  logic [1:0]                         digit_r, digit_nxt;
  logic                               tag_ok_r, tag_ok_nxt;
  logic                               spoiled_r, spoiled_nxt;
  logic [4:0]                         hv;
  logic [3:0]                         dv4;
  logic [15:0]                        lim;

  assign lim = ({3'b000, length_limit} < MaxBodyW) ? {3'b000, length_limit} : MaxBodyW;
  assign hv  = emsi_pkg::hex_value(rx_byte);

  always_comb begin
    phase_nxt    = phase_r;
    win_nxt      = win_r;
    body_len_nxt = body_len_r;
    taken_nxt    = taken_r;
    crc_nxt      = crc_r;
    rx_crc_nxt   = rx_crc_r;
    digit_nxt    = digit_r;
    tag_ok_nxt   = tag_ok_r;
    spoiled_nxt  = spoiled_r;
    win_new      = {win_r[emsi_pkg::WIN_W-9:0], rx_byte};
    len_new      = {body_len_r[11:0], hv[3:0]};
    dv4          = hv[4] ? 4'h0 : hv[3:0];
    rx_new       = {rx_crc_r[11:0], dv4};
    res          = '0;
    res.event_res = emsi_pkg::EV_NONE;
    case (phase_r)
      emsi_pkg::PH_SEARCH: begin
        if (rx_byte != 8'h00) begin
          win_nxt = win_new;
          if (win_new == emsi_pkg::SEQ_REQ) begin
            res.event_res = emsi_pkg::EV_REQ;
          end else if (win_new == emsi_pkg::SEQ_ACK) begin
            res.event_res = emsi_pkg::EV_ACK;
          end else if (win_new == emsi_pkg::SEQ_NAK) begin
            res.event_res = emsi_pkg::EV_NAK;
          end else if (win_new[emsi_pkg::DAT_W-1:0] == emsi_pkg::SEQ_DAT) begin
            win_nxt      = '0;
            crc_nxt      = emsi_pkg::CRC_INIT;
            phase_nxt    = emsi_pkg::PH_LENGTH;
            body_len_nxt = '0;
            taken_nxt    = '0;
            rx_crc_nxt   = '0;
            digit_nxt    = '0;
            tag_ok_nxt   = 1'b1;
            spoiled_nxt  = 1'b0;
          end
        end
      end
      emsi_pkg::PH_LENGTH: begin
        if (rx_byte != 8'h00) begin
          if (hv[4]) begin
            res.event_res = emsi_pkg::EV_BAD_LEN;
            phase_nxt     = emsi_pkg::PH_SEARCH;
          end else begin
            crc_nxt      = emsi_pkg::crc_byte(crc_r, rx_byte);
            body_len_nxt = len_new;
            digit_nxt    = digit_r + 2'd1;
            if (digit_r == 2'd3) begin
              if (len_new == 16'd0 || len_new > lim) begin
                res.event_res = emsi_pkg::EV_BAD_LEN;
                phase_nxt     = emsi_pkg::PH_SEARCH;
              end else begin
                phase_nxt = emsi_pkg::PH_BODY;
              end
            end
          end
        end
      end
      emsi_pkg::PH_BODY: begin
        res.data_valid = 1'b1;
        res.data_byte  = rx_byte;
        res.data_index = taken_r[11:0];
        if (rx_byte == 8'h00) begin
          spoiled_nxt = 1'b1;
        end
        if (taken_r < 13'(emsi_pkg::TAG_LEN) && rx_byte != emsi_pkg::tag_byte(taken_r[2:0])) begin
          tag_ok_nxt = 1'b0;
        end
        crc_nxt   = emsi_pkg::crc_byte(crc_r, rx_byte);
        taken_nxt = taken_r + 13'd1;
        if ({3'b000, taken_nxt} >= body_len_r) begin
          if (body_len_r < 16'(emsi_pkg::TAG_LEN)) begin
            tag_ok_nxt = 1'b0;
          end
          phase_nxt  = emsi_pkg::PH_CRC;
          digit_nxt  = '0;
          rx_crc_nxt = '0;
        end
      end
      emsi_pkg::PH_CRC: begin
        if (rx_byte != 8'h00) begin
          if (hv[4]) begin
            spoiled_nxt = 1'b1;
          end
          rx_crc_nxt = rx_new;
          digit_nxt  = digit_r + 2'd1;
          if (digit_r == 2'd3) begin
            if (spoiled_nxt || rx_new != crc_r) begin
              res.event_res = emsi_pkg::EV_BAD_CRC;
            end else if (!tag_ok_r) begin
              res.event_res = emsi_pkg::EV_BAD_TAG;
            end else begin
              res.event_res = emsi_pkg::EV_GOOD;
            end
            phase_nxt = emsi_pkg::PH_SEARCH;
          end
        end
      end
      default: begin
        phase_nxt = emsi_pkg::PH_SEARCH;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= emsi_pkg::PH_SEARCH;
      win_r      <= '0;
      body_len_r <= '0;
      taken_r    <= '0;
      crc_r      <= '0;
      rx_crc_r   <= '0;
      digit_r    <= '0;
      tag_ok_r   <= 1'b1;
      spoiled_r  <= 1'b0;
    end else if (step) begin
      phase_r    <= phase_nxt;
      win_r      <= win_nxt;
      body_len_r <= body_len_nxt;
      taken_r    <= taken_nxt;
      crc_r      <= crc_nxt;
      rx_crc_r   <= rx_crc_nxt;
      digit_r    <= digit_nxt;
      tag_ok_r   <= tag_ok_nxt;
      spoiled_r  <= spoiled_nxt;
    end
  end

endmodule

// ----- sv/emsi_frame_receiver.sv -----
// Channel  Direction  Handshake          Payload
// in_      input      in_valid/in_stall   in_rx_byte
// out_     output     out_valid/out_stall out_event_res, out_data_valid, out_data_byte,
//                                         out_data_index
// cfg_     input      cfg_valid/cfg_ready cfg_length_limit
//
// One beat per cycle sustained while out_stall is low; each byte gives one result, which
// passes the input register, then the frame state logic, into the result register.
// rst_n is synchronous, active low, and clears the frame state and the valid flags of both register stages.
// A held result stalls the input register only; one more byte is taken while it waits, if the input register is empty.
// cfg_ready is always high.
module emsi_frame_receiver #(
  parameter int unsigned MAX_BODY = emsi_pkg::MAX_BODY_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_event_res,
  output logic        out_data_valid,
  output logic [7:0]  out_data_byte,
  output logic [11:0] out_data_index,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [12:0] cfg_length_limit
);

  logic              in_vld_r;
  logic [7:0]        in_byte_r;
  logic              out_vld_r;
  emsi_pkg::result_t out_r;
  emsi_pkg::result_t res;
  logic [12:0]       limit_r;
  logic              out_blocked;
  logic              advance;
  logic              in_accept;

  assign cfg_ready   = 1'b1;
  assign out_blocked = out_vld_r && out_stall;
  assign advance     = in_vld_r && !out_blocked;
  assign in_stall    = in_vld_r && out_blocked;
  assign in_accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= emsi_pkg::LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      limit_r <= cfg_length_limit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_accept) begin
      in_vld_r <= 1'b1;
    end else if (advance) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_byte_r <= in_rx_byte;
    end
  end

  emsi_core #(
    .MAX_BODY(MAX_BODY)
  ) u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (advance),
    .rx_byte      (in_byte_r),
    .length_limit (limit_r),
    .res          (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_r <= res;
    end
  end

  assign out_valid      = out_vld_r;
  assign out_event_res  = out_r.event_res;
  assign out_data_valid = out_r.data_valid;
  assign out_data_byte  = out_r.data_byte;
  assign out_data_index = out_r.data_index;

  a_body_no_event: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_r.data_valid) |-> (out_r.event_res == emsi_pkg::EV_NONE))
    else $error("body beat carries an event");

  a_idle_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_r.data_valid) |-> (out_r.data_byte == 8'h00 && out_r.data_index == 12'h000))
    else $error("non-body beat carries data");

  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (in_vld_r && out_vld_r))
    else $error("input stalled with nothing held");

  a_advance_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_vld_r)
    else $error("result lost on advance");

endmodule
